@@ src/hptc_pkg.sv @@
package hptc_pkg;

  // queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;
  // one quotient bit per divider stage
  localparam int DIV_STAGES = 64;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P9   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H6   = 3'd5;

  localparam logic signed [63:0] PRESS_MAX   = 64'sd4294967295;
  localparam logic signed [63:0] HUM_MAX_Q   = 64'sd419430400;
  localparam logic [16:0]        HUM_Q10_MAX = 17'd102400;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [19:0] temperature_centi;
    logic [31:0]        pressure_q8;
    logic               pressure_invalid;
    logic [16:0]        humidity_q10;
  } result_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } coef_t;

  // front to back: everything but the division and its tail
  typedef struct packed {
    logic signed [23:0] tf;
    logic signed [19:0] tc;
    logic signed [63:0] num;
    logic signed [30:0] den;
    logic               bad;
    logic [16:0]        hum;
  } work_t;

  typedef struct packed {
    logic signed [23:0] tf;
    logic signed [19:0] tc;
    logic               bad;
    logic [16:0]        hum;
  } carry_t;

endpackage

@@ src/humidity_pressure_temp_compensation.sv @@
// throughput: one sample per cycle while result_ready does not stall the
// pipeline; every stage is registered, the 64-stage pressure divider retires
// one quotient bit per stage
// reset: clears all pipeline valid bits, the queue and the calibration registers
module humidity_pressure_temp_compensation import hptc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  // calibration registers, written by the user only while idle; not enforced
  logic [47:0] temp_r;
  logic [63:0] plo_r;
  logic [63:0] phi_r;
  logic [15:0] p9_r;
  logic [63:0] hum_r;
  logic [7:0]  h6_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
      hum_r  <= '0;
      h6_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP: temp_r <= cfg_data[47:0];
        REG_PLO:  plo_r  <= cfg_data;
        REG_PHI:  phi_r  <= cfg_data;
        REG_P9:   p9_r   <= cfg_data[15:0];
        REG_HUM:  hum_r  <= cfg_data;
        REG_H6:   h6_r   <= cfg_data[7:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // unpack coefficient fields
  coef_t coef;
  always_comb begin
    coef.t1 = temp_r[15:0];
    coef.t2 = temp_r[31:16];
    coef.t3 = temp_r[47:32];
    coef.p1 = plo_r[15:0];
    coef.p2 = plo_r[31:16];
    coef.p3 = plo_r[47:32];
    coef.p4 = plo_r[63:48];
    coef.p5 = phi_r[15:0];
    coef.p6 = phi_r[31:16];
    coef.p7 = phi_r[47:32];
    coef.p8 = phi_r[63:48];
    coef.p9 = p9_r;
    coef.h1 = hum_r[7:0];
    coef.h2 = hum_r[23:8];
    coef.h3 = hum_r[31:24];
    coef.h4 = hum_r[47:32];
    coef.h5 = hum_r[63:48];
    coef.h6 = h6_r;
  end

  // front: temperature, humidity and the pressure numerator / divisor
  logic  fq_valid, fq_ready;
  work_t fq_item;

  hptc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .s_valid (sample_valid),
    .s_ready (sample_ready),
    .s_data  (sample),
    .w_valid (fq_valid),
    .w_ready (fq_ready),
    .w_data  (fq_item)
  );

  // queue decouples the front from divider stalls
  logic  qb_valid, qb_ready;
  work_t qb_item;

  hptc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // back: signed division, pressure tail, output register
  hptc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .w_valid (qb_valid),
    .w_ready (qb_ready),
    .w_data  (qb_item),
    .r_valid (result_valid),
    .r_ready (result_ready),
    .r_data  (result)
  );

  // checks on the result beat
  logic signed [39:0] chk_tc;
  assign chk_tc = 40'(result.fine_temperature) * 40'sd5 + 40'sd128;

  a_bad_press_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pressure_invalid |-> result.pressure_q8 == '0)
    else $error("pressure not zero with zero divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.humidity_q10 <= HUM_Q10_MAX)
    else $error("humidity above full scale");

  a_tc_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.temperature_centi == chk_tc[27:8])
    else $error("centi temperature out of step with fine temperature");

endmodule

@@ src/hptc_front.sv @@
module hptc_front import hptc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  coef_t   coef,
  input  logic    s_valid,
  output logic    s_ready,
  input  sample_t s_data,
  output logic    w_valid,
  input  logic    w_ready,
  output work_t   w_data
);

  localparam int NF = 15;

  logic [NF-1:0] v;
  logic adv;

  assign adv     = !v[NF-1] || w_ready;
  assign s_ready = adv;
  assign w_valid = v[NF-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NF-2:0], s_valid};
    end
  end

  // carried values
  sample_t            raw_q [1:7];
  logic signed [23:0] tf_q  [3:15];
  logic signed [19:0] tc_q  [4:15];
  logic signed [28:0] ha_q  [6:10];
  logic signed [63:0] hm_q  [11:14];
  logic signed [63:0] num_q [10:15];
  logic signed [30:0] den_q [10:15];
  logic               bad_q [10:15];

  // stage registers
  logic signed [34:0] f1_ta;
  logic signed [33:0] f1_dd;
  logic signed [23:0] f2_ta;
  logic signed [37:0] f2_tb;
  logic signed [24:0] f4_pa, f4_hv;
  logic signed [49:0] f5_paa;
  logic signed [40:0] f5_pa5, f5_pa2, f5_h5v;
  logic signed [32:0] f5_hv6;
  logic signed [33:0] f5_hv3;
  logic signed [63:0] f6_pb1, f6_pa3, f6_pbc, f6_pa2s;
  logic signed [22:0] f6_x1;
  logic signed [23:0] f6_x2;
  logic signed [63:0] f7_b, f7_a2;
  logic signed [46:0] f7_x3;
  logic signed [63:0] f8_nsub, f8_a2p;
  logic signed [37:0] f8_x4;
  logic signed [63:0] f9_den, f9_num;
  logic signed [53:0] f9_x5;
  logic signed [39:0] f10_hb;
  logic [63:0]        f12_ll;
  logic [31:0]        f12_lh;
  logic signed [63:0] f13_dd;
  logic signed [63:0] f14_t;
  logic [16:0]        f15_hum;

  // combinational helpers
  logic signed [18:0] c1_dif;
  logic signed [16:0] c1_d;
  logic signed [27:0] c4_tc;
  logic signed [43:0] c6_ha;
  logic signed [53:0] c10_hb;
  logic signed [63:0] c15_h;

  always_comb begin
    c1_dif = $signed({2'b0, s_data.raw_temperature[19:3]}) - $signed({2'b0, coef.t1, 1'b0});
    c1_d   = $signed({1'b0, s_data.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
    c4_tc  = tf_q[3] * 28'sd5 + 28'sd128;
  end

  always_comb begin
    c6_ha  = $signed({14'b0, raw_q[5].raw_humidity, 14'b0}) - (44'(coef.h4) <<< 20)
             - 44'(f5_h5v) + 44'sd16384;
    c10_hb = f9_x5 + 54'sd8192;
    c15_h  = hm_q[14] - (f14_t >>> 4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_q[1] <= s_data;
      for (int k = 2; k <= 7; k++) raw_q[k] <= raw_q[k-1];

      // temperature
      f1_ta <= c1_dif * coef.t2;
      f1_dd <= c1_d * c1_d;
      f2_ta <= 24'(f1_ta >>> 11);
      f2_tb <= (f1_dd >>> 12) * coef.t3;
      tf_q[3] <= f2_ta + 24'(f2_tb >>> 14);
      for (int k = 4; k <= 15; k++) tf_q[k] <= tf_q[k-1];
      tc_q[4] <= c4_tc[27:8];
      for (int k = 5; k <= 15; k++) tc_q[k] <= tc_q[k-1];
      f4_pa <= tf_q[3] - 25'sd128000;
      f4_hv <= tf_q[3] - 25'sd76800;

      // pressure divisor and numerator
      f5_paa  <= f4_pa * f4_pa;
      f5_pa5  <= f4_pa * coef.p5;
      f5_pa2  <= f4_pa * coef.p2;
      f6_pb1  <= f5_paa * coef.p6;
      f6_pa3  <= f5_paa * coef.p3;
      f6_pbc  <= (64'(f5_pa5) <<< 17) + (64'(coef.p4) <<< 35);
      f6_pa2s <= 64'(f5_pa2) <<< 12;
      f7_b    <= f6_pb1 + f6_pbc;
      f7_a2   <= (f6_pa3 >>> 8) + f6_pa2s;
      f8_nsub <= ((64'sd1048576 - $signed({44'b0, raw_q[7].raw_pressure})) <<< 31) - f7_b;
      f8_a2p  <= f7_a2 + 64'sd140737488355328;
      f9_den  <= f8_a2p * $signed({1'b0, coef.p1});
      f9_num  <= f8_nsub * 64'sd3125;
      den_q[10] <= f9_den[63:33];
      bad_q[10] <= (f9_den[63:33] == '0);
      num_q[10] <= f9_num;
      for (int k = 11; k <= 15; k++) begin
        den_q[k] <= den_q[k-1];
        bad_q[k] <= bad_q[k-1];
        num_q[k] <= num_q[k-1];
      end

      // humidity
      f5_h5v <= f4_hv * coef.h5;
      f5_hv6 <= f4_hv * coef.h6;
      f5_hv3 <= f4_hv * $signed({1'b0, coef.h3});
      ha_q[6] <= c6_ha[43:15];
      for (int k = 7; k <= 10; k++) ha_q[k] <= ha_q[k-1];
      f6_x1  <= f5_hv6[32:10];
      f6_x2  <= 24'(f5_hv3 >>> 11) + 24'sd32768;
      f7_x3  <= f6_x1 * f6_x2;
      f8_x4  <= 38'(f7_x3 >>> 10) + 38'sd2097152;
      f9_x5  <= f8_x4 * coef.h2;
      f10_hb <= c10_hb[53:14];
      hm_q[11] <= ha_q[10] * f10_hb;
      for (int k = 12; k <= 14; k++) hm_q[k] <= hm_q[k-1];
      // square of hm >>> 15, low 64 bits from 32-bit halves
      f12_ll <= hm_q[11][46:15] * hm_q[11][46:15];
      f12_lh <= hm_q[11][46:15] * {{15{hm_q[11][63]}}, hm_q[11][63:47]};
      f13_dd <= f12_ll + {f12_lh[30:0], 33'b0};
      f14_t  <= (f13_dd >>> 7) * $signed({1'b0, coef.h1});
      if (c15_h < 0) begin
        f15_hum <= '0;
      end else if (c15_h > HUM_MAX_Q) begin
        f15_hum <= HUM_Q10_MAX;
      end else begin
        f15_hum <= c15_h[28:12];
      end
    end
  end

  always_comb begin
    w_data.tf  = tf_q[15];
    w_data.tc  = tc_q[15];
    w_data.num = num_q[15];
    w_data.den = den_q[15];
    w_data.bad = bad_q[15];
    w_data.hum = f15_hum;
  end

endmodule

@@ src/hptc_fifo.sv @@
module hptc_fifo import hptc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t          mem [DEPTH];
  logic [PW-1:0]  wp, rp;
  logic [CW-1:0]  cnt;
  logic           push, pop;

  assign push_ready = (cnt != CW'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_item   = mem[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ src/hptc_back.sv @@
module hptc_back import hptc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  coef_t   coef,
  input  logic    w_valid,
  output logic    w_ready,
  input  work_t   w_data,
  output logic    r_valid,
  input  logic    r_ready,
  output result_t r_data
);

  localparam int NP = 6;

  logic [DIV_STAGES:0] dv;
  logic [NP-1:0]       pv;
  logic                adv;

  assign adv     = !pv[NP-1] || r_ready;
  assign w_ready = adv;
  assign r_valid = pv[NP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      pv <= '0;
    end else if (adv) begin
      dv <= {dv[DIV_STAGES-1:0], w_valid};
      pv <= {pv[NP-2:0], dv[DIV_STAGES]};
    end
  end

  // divider: magnitudes, one quotient bit per stage
  logic [63:0] nq   [0:DIV_STAGES];
  logic [30:0] rem  [0:DIV_STAGES];
  logic [30:0] dm   [0:DIV_STAGES];
  logic        neg  [0:DIV_STAGES];
  carry_t      cq   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      nq[0]  <= w_data.num[63] ? 64'(-w_data.num) : 64'(w_data.num);
      dm[0]  <= w_data.den[30] ? 31'(-w_data.den) : 31'(w_data.den);
      rem[0] <= '0;
      neg[0] <= w_data.num[63] ^ w_data.den[30];
      cq[0]  <= '{tf: w_data.tf, tc: w_data.tc, bad: w_data.bad, hum: w_data.hum};
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [31:0] part;
    logic        ge;
    assign part = {rem[k-1], nq[k-1][63]};
    assign ge   = (part >= {1'b0, dm[k-1]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? 31'(part - {1'b0, dm[k-1]}) : part[30:0];
        nq[k]  <= {nq[k-1][62:0], ge};
        dm[k]  <= dm[k-1];
        neg[k] <= neg[k-1];
        cq[k]  <= cq[k-1];
      end
    end
  end

  // pressure tail
  carry_t             pc [0:NP-1];
  logic signed [63:0] p0_pr, p1_pr, p2_pr, p3_pr;
  logic signed [63:0] p1_s, p1_m, p1_p8;
  logic [63:0]        p2_ll;
  logic [31:0]        p2_lh, p2_hl;
  logic signed [63:0] p2_p8s, p3_p8s, p3_mm, p4_sum;
  logic [31:0]        p5_press;
  logic signed [63:0] c5_pr;

  assign c5_pr = (p4_sum >>> 8) + (64'(coef.p7) <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_pr  <= neg[DIV_STAGES] ? -$signed(nq[DIV_STAGES]) : $signed(nq[DIV_STAGES]);
      pc[0]  <= cq[DIV_STAGES];
      for (int k = 1; k < NP; k++) pc[k] <= pc[k-1];

      p1_pr  <= p0_pr;
      p1_s   <= p0_pr >>> 13;
      p1_m   <= coef.p9 * (p0_pr >>> 13);
      p1_p8  <= coef.p8 * p0_pr;

      // m * s, low 64 bits from 32-bit halves
      p2_ll  <= p1_m[31:0] * p1_s[31:0];
      p2_lh  <= p1_m[31:0] * p1_s[63:32];
      p2_hl  <= p1_m[63:32] * p1_s[31:0];
      p2_pr  <= p1_pr;
      p2_p8s <= p1_p8 >>> 19;

      p3_mm  <= p2_ll + {32'(p2_lh + p2_hl), 32'b0};
      p3_pr  <= p2_pr;
      p3_p8s <= p2_p8s;

      p4_sum <= p3_pr + (p3_mm >>> 25) + p3_p8s;

      if (pc[4].bad || c5_pr < 0) begin
        p5_press <= '0;
      end else if (c5_pr > PRESS_MAX) begin
        p5_press <= '1;
      end else begin
        p5_press <= c5_pr[31:0];
      end
    end
  end

  always_comb begin
    r_data.fine_temperature  = 32'(pc[NP-1].tf);
    r_data.temperature_centi = pc[NP-1].tc;
    r_data.pressure_q8       = p5_press;
    r_data.pressure_invalid  = pc[NP-1].bad;
    r_data.humidity_q10      = pc[NP-1].hum;
  end

endmodule
